/* rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Request and response item types and the request type codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  // Request type codes.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  // One request item.
  typedef struct packed {
    logic [1:0] req_type;
    logic [8:0] req_size;
    logic [7:0] req_offset;
  } req_t;

  // One response item.
  typedef struct packed {
    logic       status;
    logic [7:0] offset;
    logic [8:0] block_size;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/buddy_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// Buddy block allocator
// Allocates, frees and looks up power-of-two blocks in a pool of FRAGMENTS
// units, keeping the largest free block of every tree node in one memory.
// ----------------------------------------------------------------------------
// The block handles one request item at a time. The whole tree of
// 2*FRAGMENTS-1 nodes sits in a single-port memory with registered read
// data, so every tree level costs memory accesses. An allocate makes two
// reads per level on the way down to the level of the rounded size, then
// one read and one write per level on the way up; a free climbs from the
// leaf with one read per level to the used block, writes it free and
// refreshes the levels above it the same way; a size query only climbs.
// A rejected size or request code goes straight to the result, an allocate
// that finds no room stops at the root, and a free or query that meets no
// used block climbs to the root. A finished result may wait on a stalled
// output register. After reset the block writes the free tree into the
// memory and stalls its input meanwhile. A finished result waits in an
// output register, so the next item is taken while it is still unread.
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator_top #(
  parameter int FRAGMENTS = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bba_pkg::req_t in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bba_pkg::rsp_t      out_item_o
);

  localparam int LG    = $clog2(FRAGMENTS);
  localparam int IW    = LG + 1;
  localparam int VW    = LG + 1;
  localparam int LW    = $clog2(LG + 1);
  localparam int NODES = 2 * FRAGMENTS - 1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_ROOT,
    ST_A_LEFT,
    ST_A_RIGHT,
    ST_A_MARK,
    ST_F_FIND,
    ST_CLIMB_RD,
    ST_CLIMB_WR,
    ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [LW-1:0]   lg_q, lg_d;
  logic [LW-1:0]   sz_lg_q, sz_lg_d;
  logic [LG-1:0]   off_q, off_d;
  logic [VW-1:0]   lv_q, lv_d;
  logic [VW-1:0]   cur_q, cur_d;
  logic            merge_q, merge_d;
  logic            query_q, query_d;
  bba_pkg::rsp_t   res_q, res_d;
  logic            out_valid_q, out_valid_d;
  bba_pkg::rsp_t   out_item_q, out_item_d;
  logic [IW-1:0]   clr_idx_q, clr_idx_d;
  logic [VW-1:0]   clr_val_q, clr_val_d;

  // Tree memory port.
  logic [VW-1:0]   mem [NODES];
  logic [VW-1:0]   mem_rdata_q;
  logic            mem_we;
  logic [IW-1:0]   mem_addr;
  logic [VW-1:0]   mem_wdata;

  // Request decode.
  logic [8:0]      req_rm1;
  logic [3:0]      req_lg;
  logic            req_bad_size;
  logic            off_bad;
  logic [IW-1:0]   leaf_idx;

  // Tree navigation.
  logic [IW-1:0]   left_idx;
  logic [IW-1:0]   right_idx;
  logic [IW-1:0]   parent_idx;
  logic [IW-1:0]   sib_idx;
  logic [VW-1:0]   size_val;
  logic            go_left;
  logic [IW-1:0]   pick_idx;
  logic [LG-1:0]   pick_off;
  logic [IW-1:0]   pick_left;

  // Climb update.
  logic [LW-1:0]   plg;
  logic [VW-1:0]   full_val;
  logic [VW:0]     pair_sum;
  logic [VW-1:0]   max_val;
  logic [VW-1:0]   new_val;
  logic [VW-1:0]   blk_val;
  logic [LG-1:0]   blk_start;
  logic            can_load;

  // Round the requested size up to a power of two, as an exponent.
  assign req_rm1 = in_item_i.req_size - 9'd1;
  always_comb begin
    req_lg = '0;
    for (int b = 0; b < 9; b++) begin
      if (req_rm1[b]) begin
        req_lg = 4'(b + 1);
      end
    end
  end

  assign req_bad_size = (in_item_i.req_size == 9'd0) ||
                        (32'(in_item_i.req_size) > 32'(FRAGMENTS));
  assign off_bad      = 32'(in_item_i.req_offset) >= 32'(FRAGMENTS);
  assign leaf_idx     = off_bad ? '0 :
                        IW'(32'(in_item_i.req_offset) + 32'(FRAGMENTS) - 32'd1);

  // Heap-style node arithmetic.
  assign left_idx   = {idx_q[IW-2:0], 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign parent_idx = ((idx_q + IW'(1)) >> 1) - IW'(1);
  assign sib_idx    = idx_q[0] ? idx_q + IW'(1) : idx_q - IW'(1);
  assign size_val   = VW'(1) << sz_lg_q;

  // Best fit: the child with the smaller free block that still holds the size.
  always_comb begin
    go_left = (lv_q <= mem_rdata_q);
    if (size_val > (go_left ? lv_q : mem_rdata_q)) begin
      go_left = !go_left;
    end
  end
  assign pick_idx  = go_left ? left_idx : right_idx;
  assign pick_off  = go_left ? off_q : off_q + (LG'(1) << (lg_q - LW'(1)));
  assign pick_left = {pick_idx[IW-2:0], 1'b1};

  // Parent value from the updated child and its sibling; a free merges buddies.
  assign plg      = lg_q + LW'(1);
  assign full_val = VW'(1) << plg;
  assign pair_sum = {1'b0, cur_q} + {1'b0, mem_rdata_q};
  assign max_val  = (cur_q > mem_rdata_q) ? cur_q : mem_rdata_q;
  assign new_val  = (merge_q && (pair_sum == {1'b0, full_val})) ? full_val : max_val;

  // Block found by the leaf climb.
  assign blk_val   = VW'(1) << lg_q;
  assign blk_start = off_q & ~((LG'(1) << lg_q) - LG'(1));

  assign can_load = !out_valid_q || !out_stall_i;

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    lg_d        = lg_q;
    sz_lg_d     = sz_lg_q;
    off_d       = off_q;
    lv_d        = lv_q;
    cur_d       = cur_q;
    merge_d     = merge_q;
    query_d     = query_q;
    res_d       = res_q;
    out_item_d  = out_item_q;
    clr_idx_d   = clr_idx_q;
    clr_val_d   = clr_val_q;
    mem_we      = 1'b0;
    mem_addr    = idx_q;
    mem_wdata   = '0;

    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx_q;
        mem_wdata = clr_val_q;
        if (clr_idx_q == IW'(NODES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_idx_d = clr_idx_q + IW'(1);
          if (((clr_idx_q + IW'(2)) & (clr_idx_q + IW'(1))) == '0) begin
            clr_val_d = clr_val_q >> 1;
          end
        end
      end

      ST_IDLE: begin
        mem_addr = (in_item_i.req_type == bba_pkg::REQ_ALLOC) ? '0 : leaf_idx;
        if (in_valid_i) begin
          res_d   = '{status: 1'b1, offset: 8'd0, block_size: 9'd0};
          state_d = ST_DONE;
          unique case (in_item_i.req_type)
            bba_pkg::REQ_ALLOC: begin
              if (!req_bad_size) begin
                sz_lg_d = LW'(req_lg);
                idx_d   = '0;
                lg_d    = LW'(LG);
                off_d   = '0;
                state_d = ST_A_ROOT;
              end
            end
            bba_pkg::REQ_FREE, bba_pkg::REQ_QUERY: begin
              if (!off_bad) begin
                idx_d   = leaf_idx;
                lg_d    = '0;
                off_d   = LG'(32'(in_item_i.req_offset));
                query_d = (in_item_i.req_type == bba_pkg::REQ_QUERY);
                state_d = ST_F_FIND;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // Root value is back: check that the pool can hold the size.
      ST_A_ROOT: begin
        if (mem_rdata_q < size_val) begin
          state_d = ST_DONE;
        end else if (lg_q == sz_lg_q) begin
          state_d = ST_A_MARK;
        end else begin
          mem_addr = left_idx;
          state_d  = ST_A_LEFT;
        end
      end

      ST_A_LEFT: begin
        lv_d     = mem_rdata_q;
        mem_addr = right_idx;
        state_d  = ST_A_RIGHT;
      end

      // Both children known: step down one level.
      ST_A_RIGHT: begin
        idx_d = pick_idx;
        off_d = pick_off;
        lg_d  = lg_q - LW'(1);
        if ((lg_q - LW'(1)) == sz_lg_q) begin
          state_d = ST_A_MARK;
        end else begin
          mem_addr = pick_left;
          state_d  = ST_A_LEFT;
        end
      end

      ST_A_MARK: begin
        mem_we    = 1'b1;
        mem_addr  = idx_q;
        mem_wdata = '0;
        cur_d     = '0;
        merge_d   = 1'b0;
        res_d     = '{status: 1'b0, offset: 8'(32'(off_q)),
                      block_size: 9'(32'd1 << lg_q)};
        state_d   = (idx_q == '0) ? ST_DONE : ST_CLIMB_RD;
      end

      // Climb from the leaf until a used node turns up.
      ST_F_FIND: begin
        if (mem_rdata_q == '0) begin
          res_d = '{status: 1'b0, offset: 8'(32'(blk_start)),
                    block_size: 9'(32'd1 << lg_q)};
          if (query_q) begin
            state_d = ST_DONE;
          end else begin
            mem_we    = 1'b1;
            mem_addr  = idx_q;
            mem_wdata = blk_val;
            cur_d     = blk_val;
            merge_d   = 1'b1;
            state_d   = (idx_q == '0) ? ST_DONE : ST_CLIMB_RD;
          end
        end else if (idx_q == '0) begin
          state_d = ST_DONE;
        end else begin
          idx_d    = parent_idx;
          lg_d     = lg_q + LW'(1);
          mem_addr = parent_idx;
        end
      end

      ST_CLIMB_RD: begin
        mem_addr = sib_idx;
        state_d  = ST_CLIMB_WR;
      end

      ST_CLIMB_WR: begin
        mem_we    = 1'b1;
        mem_addr  = parent_idx;
        mem_wdata = new_val;
        cur_d     = new_val;
        idx_d     = parent_idx;
        lg_d      = plg;
        state_d   = (parent_idx == '0) ? ST_DONE : ST_CLIMB_RD;
      end

      ST_DONE: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_item_d  = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      lg_q        <= '0;
      sz_lg_q     <= '0;
      off_q       <= '0;
      lv_q        <= '0;
      cur_q       <= '0;
      merge_q     <= 1'b0;
      query_q     <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      clr_idx_q   <= '0;
      clr_val_q   <= VW'(FRAGMENTS);
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      lg_q        <= lg_d;
      sz_lg_q     <= sz_lg_d;
      off_q       <= off_d;
      lv_q        <= lv_d;
      cur_q       <= cur_d;
      merge_q     <= merge_d;
      query_q     <= query_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
      clr_idx_q   <= clr_idx_d;
      clr_val_q   <= clr_val_d;
    end
  end

  // Single-port tree memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A failed result carries no offset and no size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status) |->
      (out_item_o.offset == 8'd0 && out_item_o.block_size == 9'd0))
    else $error("failed result with nonzero offset or size");

  // The descent stops exactly at the level of the rounded size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A_MARK) |-> (lg_q == sz_lg_q))
    else $error("allocate marked a node at the wrong level");

  // The upward refresh never reads a sibling of the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLIMB_RD) |-> (idx_q != '0))
    else $error("climb continued past the root");

endmodule

`default_nettype wire
